FILE: src/wavetable_lfo_with_fade_in_macros.svh
// Assertion macros used by the port-level checker.
`ifndef WAVETABLE_LFO_WITH_FADE_IN_MACROS_SVH
`define WAVETABLE_LFO_WITH_FADE_IN_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define WLFO_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define WLFO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/wlfo_pkg.sv
// Shared constants, types and table functions for the wavetable LFO.
package wlfo_pkg;

	localparam int TABLE_SIZE          = 2048;
	localparam int MAX_STEPS           = 128;
	localparam int PHASE_FRACTION_BITS = 16;

	localparam int TB = $clog2(TABLE_SIZE);
	localparam int SB = $clog2(MAX_STEPS);
	localparam int NB = $clog2(MAX_STEPS + 1);
	localparam int AW = (TB > SB) ? TB : SB;
	localparam int PB = TB + PHASE_FRACTION_BITS;
	localparam int VW = 17;
	localparam int MB = (PHASE_FRACTION_BITS + 1 > VW) ? PHASE_FRACTION_BITS + 1 : VW;
	localparam int PW = VW + MB;
	localparam int DCW = $clog2(NB + 1);

	localparam int OP_W   = 3;
	localparam int ADDR_W = 11;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 27;
	localparam int INC_W  = 27;

	localparam logic [VW-1:0] ONE_Q16    = VW'(65536);
	localparam logic [MB-1:0] FRAC_WHOLE = MB'(1) << PHASE_FRACTION_BITS;
	localparam logic [15:0]   NOISE_SEED = 16'hACE1;
	localparam logic [15:0]   NOISE_TAPS = 16'hB400;
	localparam longint        Q30        = 64'sd1073741824;

	typedef enum logic [OP_W-1:0] {
		OP_TICK, OP_NOTE_ON, OP_NOTE_OFF, OP_ALL_OFF, OP_WR_CUSTOM, OP_WR_STEP
	} op_t;

	typedef enum logic [2:0] {
		WF_SINE, WF_TRIANGLE, WF_SAW, WF_SQUARE, WF_RANDOM, WF_CUSTOM, WF_STEPS
	} wave_t;

	typedef enum logic [CFG_AW-1:0] {
		CR_WAVEFORM, CR_PHASE_INC, CR_LOOP, CR_LEGATO,
		CR_STEP_COUNT, CR_FADE_EN, CR_FADE_BASE, CR_FADE_COEF
	} cfg_reg_t;

	typedef enum logic [2:0] {
		SRC_SINE, SRC_TRI, SRC_SAW, SRC_SQUARE, SRC_CUSTOM, SRC_STEP
	} src_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_NOTE_RD, ST_NOTE_WB, ST_TICK, ST_DIV, ST_STEP_RD, ST_STEP_WB,
		ST_END_WB, ST_RD_B, ST_MUL_B, ST_MIX, ST_FADE, ST_FADE_WB, ST_OUT_MUL, ST_OUT
	} state_t;

	typedef struct packed {
		logic          en;
		src_t          src;
		logic [AW-1:0] addr;
	} rd_req_t;

	typedef struct packed {
		logic          custom_en;
		logic          step_en;
		logic [AW-1:0] addr;
		logic [VW-1:0] data;
	} wr_req_t;

	typedef logic [VW-1:0] sine_rom_t [TABLE_SIZE];

	// cos(pi/2 * t), t and result in Q30
	function automatic longint quarter_cos(longint t);
		longint coef [7] = '{64'sd1073741824, 64'sd1324675879, 64'sd272375560,
			64'sd22401995, 64'sd987047, 64'sd27061, 64'sd506};
		longint u;
		longint p;
		longint s;
		longint term;
		u = (t * t) >>> 30;
		p = Q30;
		s = Q30;
		for (int k = 1; k < 7; k++) begin
			p = (p * u) >>> 30;
			term = (coef[k] * p) >>> 30;
			if ((k % 2) == 1) s = s - term;
			else s = s + term;
		end
		if (s < 0) s = 0;
		if (s > Q30) s = Q30;
		return s;
	endfunction

	function automatic logic [VW-1:0] sine_entry(int i);
		longint p;
		longint quad;
		longint r;
		longint t;
		longint c;
		longint mag;
		p = 4 * longint'(i);
		quad = p / TABLE_SIZE;
		r = p % TABLE_SIZE;
		t = (r <<< 30) / TABLE_SIZE;
		if (quad == 0 || quad == 2) c = quarter_cos(t);
		else c = quarter_cos(Q30 - t);
		mag = (c * 32768 + Q30 / 2) >>> 30;
		if (quad == 1 || quad == 2) return VW'(32768 - mag);
		return VW'(32768 + mag);
	endfunction

	function automatic sine_rom_t build_sine();
		sine_rom_t rom;
		for (int i = 0; i < TABLE_SIZE; i++) rom[i] = sine_entry(i);
		return rom;
	endfunction

	// triangle, saw and square entries, floored Q16
	function automatic logic [VW-1:0] shape_entry(src_t src, logic [TB-1:0] i);
		int twoi;
		int saw;
		logic upper;
		twoi = (int'(i) * 131072) / TABLE_SIZE;
		saw = (int'(i) * 65536) / TABLE_SIZE;
		upper = i[TB-1];
		unique case (src)
			SRC_TRI:    return upper ? VW'(twoi - 65536) : VW'(65536 - twoi);
			SRC_SAW:    return VW'(saw);
			SRC_SQUARE: return upper ? '0 : ONE_Q16;
			default:    return '0;
		endcase
	endfunction

endpackage

FILE: src/wlfo_if.sv
// Request, result and configuration channel interfaces.
interface wlfo_item_if;
	logic                          valid;
	logic                          ready;
	logic [wlfo_pkg::OP_W-1:0]     operation;
	logic [wlfo_pkg::ADDR_W-1:0]   table_address;
	logic [wlfo_pkg::VW-1:0]       table_value;
	modport source (output valid, operation, table_address, table_value, input ready);
	modport sink (input valid, operation, table_address, table_value, output ready);
endinterface

interface wlfo_result_if;
	logic                    valid;
	logic                    ready;
	logic [wlfo_pkg::VW-1:0] mod_value;
	modport source (output valid, mod_value, input ready);
	modport sink (input valid, mod_value, output ready);
endinterface

interface wlfo_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [wlfo_pkg::CFG_AW-1:0] addr;
	logic [wlfo_pkg::CFG_DW-1:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

FILE: src/wlfo_tables.sv
// Waveform ROMs, custom table and step memory with one registered read port.
module wlfo_tables (
	input  logic                    clk,
	input  wlfo_pkg::rd_req_t       rd,
	input  wlfo_pkg::wr_req_t       wr,
	output logic [wlfo_pkg::VW-1:0] rd_data
);
	import wlfo_pkg::*;

	localparam sine_rom_t SINE_ROM = build_sine();

	logic [VW-1:0] custom_mem [TABLE_SIZE];
	logic [VW-1:0] step_mem [MAX_STEPS];
	logic [VW-1:0] custom_q, step_q, sine_q, shape_q;
	src_t          src_q;

	always_ff @(posedge clk) begin
		if (wr.custom_en) custom_mem[wr.addr[TB-1:0]] <= wr.data;
		if (wr.step_en) step_mem[wr.addr[SB-1:0]] <= wr.data;
		if (rd.en) begin
			custom_q <= custom_mem[rd.addr[TB-1:0]];
			step_q   <= step_mem[rd.addr[SB-1:0]];
			sine_q   <= SINE_ROM[rd.addr[TB-1:0]];
			shape_q  <= shape_entry(rd.src, rd.addr[TB-1:0]);
			src_q    <= rd.src;
		end
	end

	always_comb begin
		unique case (src_q)
			SRC_CUSTOM:                  rd_data = custom_q;
			SRC_STEP:                    rd_data = step_q;
			SRC_TRI, SRC_SAW, SRC_SQUARE: rd_data = shape_q;
			default:                     rd_data = sine_q;
		endcase
	end

endmodule

FILE: src/wlfo_mul.sv
// Shared multiplier with registered product.
module wlfo_mul (
	input  logic                    clk,
	input  logic [wlfo_pkg::VW-1:0] a,
	input  logic [wlfo_pkg::MB-1:0] b,
	output logic [wlfo_pkg::PW-1:0] p_s1
);
	import wlfo_pkg::*;

	always_ff @(posedge clk) begin
		p_s1 <= PW'(a) * PW'(b);
	end

endmodule

FILE: src/wavetable_lfo_with_fade_in.sv
// Wavetable LFO top level: sequencer, state registers and config registers.
// A tick passes ST_TICK, ST_FADE, ST_FADE_WB, ST_OUT_MUL, ST_OUT. A table wave adds
// ST_RD_B to ST_MIX, a new end value ST_END_WB, a steps wrap ST_DIV to ST_STEP_WB.
// Throughput: one request at a time; ready returns in the cycle the result goes
// valid. Set by the single shared multiplier and single table read port.
// A restarting note on in steps mode also runs ST_NOTE_RD and ST_NOTE_WB.
// arst_n clears config to defaults and LFO state; table contents stay undefined.
module wavetable_lfo_with_fade_in (
	input logic           clk,
	input logic           arst_n,
	wlfo_cfg_if.sink      cfg,
	wlfo_item_if.sink     item,
	wlfo_result_if.source result
);
	import wlfo_pkg::*;

	// config registers
	logic [2:0]       waveform_q;
	logic [INC_W-1:0] phase_inc_q;
	logic             loop_q, legato_q, fade_en_q;
	logic [7:0]       step_count_q;
	logic [VW-1:0]    fade_base_q, fade_coef_q;

	// LFO state
	state_t        state_q, state_d;
	logic [PB-1:0] phase_q;
	logic          fpd_q;          // first pass done
	logic [SB-1:0] si_q;           // step index
	logic [VW-1:0] held_q;
	logic          ev_q;           // end value latched
	logic [VW-1:0] end_q;
	logic [VW-1:0] fade_q;
	logic [7:0]    key_q;
	logic [15:0]   noise_q;

	// per-tick work registers
	logic [TB-1:0]                  idx_q;
	logic [PHASE_FRACTION_BITS-1:0] frac_q;
	src_t                           src_sel_q;
	logic [VW-1:0]                  w_q;
	logic [PW-1:0]                  acc_q;
	logic [NB-1:0]                  rem_q, x_q;
	logic [DCW-1:0]                 cnt_q;
	logic                           out_valid_q;
	logic [VW-1:0]                  out_data_q;

	rd_req_t       rd;
	wr_req_t       wr;
	logic [VW-1:0] rd_data;
	logic [VW-1:0] mul_a;
	logic [MB-1:0] mul_b;
	logic [PW-1:0] p_s1;

	wlfo_tables u_tables (.clk, .rd, .wr, .rd_data);
	wlfo_mul u_mul (.clk, .a(mul_a), .b(mul_b), .p_s1);

	// request decode
	logic accept, restart, out_free;
	logic [VW-1:0] val_sat;
	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign restart    = !legato_q || (key_q == 8'd0);
	assign val_sat    = (item.table_value > ONE_Q16) ? ONE_Q16 : item.table_value;
	assign out_free   = !out_valid_q || result.ready;

	// table writes go straight to the memories in the accept cycle
	always_comb begin
		wr.custom_en = accept && (item.operation == OP_WR_CUSTOM)
			&& (int'(item.table_address) < TABLE_SIZE);
		wr.step_en   = accept && (item.operation == OP_WR_STEP)
			&& (int'(item.table_address) < MAX_STEPS);
		wr.addr      = AW'(item.table_address);
		wr.data      = val_sat;
	end

	// tick conditions, all from state at tick start
	logic [PB:0]                    sum;
	logic                           wrap;
	logic [TB-1:0]                  idx;
	logic [PHASE_FRACTION_BITS-1:0] frac;
	logic [NB-1:0]                  n_use;
	logic                           is_random, is_steps, is_custom, custom_end, step_end;
	src_t                           wave_src;
	logic [15:0]                    noise_nxt;

	assign sum  = {1'b0, phase_q} + (PB + 1)'(phase_inc_q);
	assign wrap = sum[PB];
	assign idx  = phase_q[PB-1:PHASE_FRACTION_BITS];
	assign frac = phase_q[PHASE_FRACTION_BITS-1:0];
	assign is_random = (waveform_q == WF_RANDOM);
	assign is_steps  = (waveform_q == WF_STEPS);
	assign is_custom = (waveform_q == WF_CUSTOM);
	// beyond the last entry, or already wrapped once: hold the end value
	assign custom_end = !loop_q && is_custom
		&& (fpd_q || ((idx == {TB{1'b1}}) && (frac != '0)));
	assign step_end = !loop_q && ((NB'(si_q) + NB'(1)) == n_use);
	assign noise_nxt = noise_q[0] ? ((noise_q >> 1) ^ NOISE_TAPS) : (noise_q >> 1);

	always_comb begin
		if (step_count_q == 8'd0) n_use = NB'(1);
		else if (int'(step_count_q) > MAX_STEPS) n_use = NB'(MAX_STEPS);
		else n_use = NB'(step_count_q);
	end

	always_comb begin
		unique case (waveform_q)
			WF_TRIANGLE: wave_src = SRC_TRI;
			WF_SAW:      wave_src = SRC_SAW;
			WF_SQUARE:   wave_src = SRC_SQUARE;
			WF_CUSTOM:   wave_src = SRC_CUSTOM;
			default:     wave_src = SRC_SINE;
		endcase
	end

	// modulo step: one restoring-division bit per cycle
	logic [NB:0]   div_t;
	logic [NB-1:0] rem_nxt;
	assign div_t   = {rem_q, x_q[NB-1]};
	assign rem_nxt = (div_t >= (NB + 1)'(n_use)) ? NB'(div_t - (NB + 1)'(n_use)) : NB'(div_t);

	// interpolation sum and fade update
	logic [PW:0]                           mix_sum;
	logic [PW-PHASE_FRACTION_BITS:0]       mix;
	logic [VW-1:0]                         mix_clamp;
	logic [PW-16:0]                        fade_sum;
	logic [VW-1:0]                         fresh, end_new;
	logic [VW:0]                           avg_sum;
	assign mix_sum   = {1'b0, acc_q} + {1'b0, p_s1};
	assign mix       = mix_sum[PW:PHASE_FRACTION_BITS];
	assign mix_clamp = (mix > (PW - PHASE_FRACTION_BITS + 1)'(ONE_Q16)) ? ONE_Q16 : VW'(mix);
	assign fade_sum  = (PW - 15)'(fade_base_q) + (PW - 15)'(p_s1[PW-1:16]);
	assign fresh     = ONE_Q16 - rd_data;
	assign end_new   = ONE_Q16 - rd_data;
	assign avg_sum   = {1'b0, fresh} + {1'b0, held_q};

	// sequencer: next state, read port and multiplier operands
	always_comb begin
		state_d  = state_q;
		rd.en    = 1'b0;
		rd.src   = src_sel_q;
		rd.addr  = '0;
		mul_a    = w_q;
		mul_b    = MB'(fade_q);
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (item.operation == OP_TICK) state_d = ST_TICK;
					else if (item.operation == OP_NOTE_ON && restart && is_steps)
						state_d = ST_NOTE_RD;
				end
			end
			ST_NOTE_RD: begin
				rd.en   = 1'b1;
				rd.src  = SRC_STEP;
				state_d = ST_NOTE_WB;
			end
			ST_NOTE_WB: state_d = ST_IDLE;
			ST_TICK: begin
				if (is_random) state_d = ST_FADE;
				else if (is_steps) begin
					if (!wrap) state_d = ST_FADE;
					else if (step_end) begin
						if (ev_q) state_d = ST_FADE;
						else begin
							rd.en   = 1'b1;
							rd.src  = SRC_STEP;
							rd.addr = AW'(n_use - NB'(1));
							state_d = ST_END_WB;
						end
					end else state_d = ST_DIV;
				end else if (custom_end) begin
					if (ev_q) state_d = ST_FADE;
					else begin
						rd.en   = 1'b1;
						rd.src  = SRC_CUSTOM;
						rd.addr = AW'(TABLE_SIZE - 1);
						state_d = ST_END_WB;
					end
				end else begin
					rd.en   = 1'b1;
					rd.src  = wave_src;
					rd.addr = AW'(idx);
					state_d = ST_RD_B;
				end
			end
			ST_DIV: if (cnt_q == DCW'(NB - 1)) state_d = ST_STEP_RD;
			ST_STEP_RD: begin
				rd.en   = 1'b1;
				rd.src  = SRC_STEP;
				rd.addr = AW'(rem_q);
				state_d = ST_STEP_WB;
			end
			ST_STEP_WB: state_d = ST_FADE;
			ST_END_WB:  state_d = ST_FADE;
			ST_RD_B: begin
				// rd_data is the entry at idx; fetch the next one
				rd.en   = 1'b1;
				rd.addr = AW'(idx_q + TB'(1));
				mul_a   = rd_data;
				mul_b   = FRAC_WHOLE - MB'(frac_q);
				state_d = ST_MUL_B;
			end
			ST_MUL_B: begin
				mul_a   = rd_data;
				mul_b   = MB'(frac_q);
				state_d = ST_MIX;
			end
			ST_MIX: state_d = ST_FADE;
			ST_FADE: begin
				mul_a   = fade_q;
				mul_b   = MB'(fade_coef_q);
				state_d = ST_FADE_WB;
			end
			ST_FADE_WB: state_d = ST_OUT_MUL;
			ST_OUT_MUL: state_d = ST_OUT;
			ST_OUT:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// configuration registers
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q   <= WF_SINE;
			phase_inc_q  <= '0;
			loop_q       <= 1'b1;
			legato_q     <= 1'b1;
			step_count_q <= 8'd16;
			fade_en_q    <= 1'b1;
			fade_base_q  <= '0;
			fade_coef_q  <= ONE_Q16;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.addr))
				CR_WAVEFORM:   waveform_q   <= cfg.data[2:0];
				CR_PHASE_INC:  phase_inc_q  <= cfg.data[INC_W-1:0];
				CR_LOOP:       loop_q       <= cfg.data[0];
				CR_LEGATO:     legato_q     <= cfg.data[0];
				CR_STEP_COUNT: step_count_q <= cfg.data[7:0];
				CR_FADE_EN:    fade_en_q    <= cfg.data[0];
				CR_FADE_BASE:  fade_base_q  <= cfg.data[VW-1:0];
				CR_FADE_COEF:  fade_coef_q  <= cfg.data[VW-1:0];
			endcase
		end
	end

	// LFO state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			fpd_q       <= 1'b0;
			si_q        <= '0;
			held_q      <= ONE_Q16;
			ev_q        <= 1'b0;
			end_q       <= '0;
			fade_q      <= '0;
			key_q       <= '0;
			noise_q     <= NOISE_SEED;
			out_valid_q <= 1'b0;
		end else begin
			// a new result takes priority over the drain of the old one
			if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && result.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.operation == OP_NOTE_ON) begin
							if (restart) begin
								phase_q <= '0;
								fpd_q   <= 1'b0;
								ev_q    <= 1'b0;
								if (is_steps) si_q <= '0;
								fade_q  <= fade_en_q ? '0 : ONE_Q16;
							end
							if (key_q != 8'hFF) key_q <= key_q + 8'd1;
						end else if (item.operation == OP_NOTE_OFF) begin
							if (key_q != 8'd0) key_q <= key_q - 8'd1;
						end else if (item.operation == OP_ALL_OFF) begin
							key_q <= '0;
						end
					end
				end
				ST_NOTE_WB: held_q <= fresh;
				ST_TICK: begin
					phase_q <= sum[PB-1:0];
					if (wrap) fpd_q <= 1'b1;
					if (is_random && wrap) begin
						noise_q <= noise_nxt;
						held_q  <= {1'b0, noise_nxt};
					end else if (is_steps && wrap && step_end && ev_q) begin
						held_q <= end_q;
					end
				end
				ST_STEP_RD: si_q <= rem_q[SB-1:0];
				ST_STEP_WB: held_q <= fresh;
				ST_END_WB: begin
					end_q <= end_new;
					ev_q  <= 1'b1;
					if (is_steps) held_q <= end_new;
				end
				ST_FADE_WB: begin
					if (fade_en_q || fade_q < ONE_Q16)
						fade_q <= (fade_sum > (PW - 15)'(ONE_Q16)) ? ONE_Q16 : VW'(fade_sum);
					else fade_q <= ONE_Q16;
				end
				default: ;
			endcase
		end
	end

	// per-tick work registers, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_TICK: begin
				idx_q     <= idx;
				frac_q    <= frac;
				src_sel_q <= wave_src;
				rem_q     <= '0;
				cnt_q     <= '0;
				// one whole cycle crossed: advance by one unless a single step
				x_q       <= NB'(si_q) + ((n_use == NB'(1)) ? NB'(0) : NB'(1));
				if (is_random) w_q <= wrap ? {1'b0, noise_nxt} : held_q;
				else if (is_steps) w_q <= (wrap && step_end && ev_q) ? end_q : held_q;
				else w_q <= end_q;
			end
			ST_DIV: begin
				rem_q <= rem_nxt;
				x_q   <= x_q << 1;
				cnt_q <= cnt_q + DCW'(1);
			end
			ST_STEP_WB: w_q <= avg_sum[VW:1];
			ST_END_WB:  w_q <= end_new;
			ST_MUL_B:   acc_q <= p_s1;
			ST_MIX:     w_q <= ONE_Q16 - mix_clamp;
			ST_OUT:     if (out_free) out_data_q <= ONE_Q16 - VW'(p_s1[PW-1:16]);
			default: ;
		endcase
	end

	assign result.valid     = out_valid_q;
	assign result.mod_value = out_data_q;

endmodule

FILE: src/wlfo_checker.sv
// Port-level checker for the wavetable LFO, bound to the top level.
`include "wavetable_lfo_with_fade_in_macros.svh"

module wlfo_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            item_valid,
	input logic                            item_ready,
	input logic [wlfo_pkg::OP_W-1:0]       operation,
	input logic                            result_valid,
	input logic                            result_ready,
	input logic [wlfo_pkg::VW-1:0]         mod_value
);
	import wlfo_pkg::*;

	`WLFO_ASSERT_NEXT(a_result_holds, result_valid && !result_ready, result_valid && $stable(mod_value), "result dropped or changed under stall")
	`WLFO_ASSERT_NOW(a_value_range, result_valid, mod_value <= ONE_Q16, "mod_value above 1.0")
	`WLFO_ASSERT_NEXT(a_tick_busy, item_valid && item_ready && operation == OP_TICK, !item_ready, "ready during tick processing")
	`WLFO_ASSERT_NEXT(a_no_spurious, item_valid && item_ready && operation != OP_TICK, !$rose(result_valid), "result from a non-tick request")

endmodule

bind wavetable_lfo_with_fade_in wlfo_checker u_wlfo_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.operation    (item.operation),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.mod_value    (result.mod_value)
);

FILE: dv/testbench.sv
// Self-checking testbench for the wavetable LFO with fade-in.
module testbench;
	import wlfo_pkg::*;

	localparam int          LIMIT      = 1000000;
	localparam int          DRAIN_WAIT = 24;     // longer than the slowest tick without back-pressure
	localparam logic [2:0]  OP_BAD_LO  = 3'd6;
	localparam logic [2:0]  OP_BAD_HI  = 3'd7;
	localparam logic [2:0]  WF_INVALID = 3'd7;
	localparam longint      PHASE_WRAP = longint'(TABLE_SIZE) << PHASE_FRACTION_BITS;
	localparam longint      UNIT       = 65536;

	logic clk;
	logic arst_n;

	wlfo_cfg_if    cfg_ch ();
	wlfo_item_if   req_ch ();
	wlfo_result_if res_ch ();

	wavetable_lfo_with_fade_in u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch.sink),
		.item   (req_ch.sink),
		.result (res_ch.source)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Shadow LFO: config copy, state copy and its own wave tables
	// ---------------------------------------------------------------
	logic [2:0]  sh_wave;
	longint      sh_inc;
	bit          sh_loop, sh_legato, sh_fade_en;
	int          sh_steps_cfg;
	longint      sh_fade_base, sh_fade_coef;

	longint      lfo_phase;
	bit          lfo_wrapped_once;
	int          lfo_step;
	longint      lfo_held;
	bit          lfo_end_latched;
	longint      lfo_end;
	longint      lfo_fade;
	int          lfo_keys;
	logic [15:0] lfo_noise;
	longint      lfo_custom [TABLE_SIZE];
	longint      lfo_step_vals [MAX_STEPS];
	longint      sine_tab [TABLE_SIZE];

	logic [VW-1:0] mod_expected [$];
	int            mismatches;
	int            cycle_count;
	int            send_idle_pct, recv_idle_pct;

	// quarter-wave cosine, Q30 in and out, fixed 7-term polynomial
	function automatic longint cos_q30(longint t);
		longint k_tab [7];
		longint u, pw, acc, term;
		k_tab = '{64'sd1073741824, 64'sd1324675879, 64'sd272375560, 64'sd22401995,
			64'sd987047, 64'sd27061, 64'sd506};
		u = (t * t) >>> 30;
		pw = 64'sd1073741824;
		acc = pw;
		for (int k = 1; k < 7; k++) begin
			pw = (pw * u) >>> 30;
			term = (k_tab[k] * pw) >>> 30;
			acc = (k % 2 == 1) ? acc - term : acc + term;
		end
		if (acc < 0) acc = 0;
		if (acc > 64'sd1073741824) acc = 64'sd1073741824;
		return acc;
	endfunction

	function automatic longint shape_value(logic [2:0] wf, int i);
		longint twoi;
		twoi = (longint'(i) * 2 * UNIT) / TABLE_SIZE;
		case (wf)
			WF_TRIANGLE: return (i >= TABLE_SIZE / 2) ? twoi - UNIT : UNIT - twoi;
			WF_SAW:      return (longint'(i) * UNIT) / TABLE_SIZE;
			WF_SQUARE:   return (i >= TABLE_SIZE / 2) ? 0 : UNIT;
			WF_CUSTOM:   return lfo_custom[i];
			default:     return sine_tab[i];
		endcase
	endfunction

	function automatic void lfo_reset();
		longint p, quad, r, c, mag;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			p = 4 * longint'(i);
			quad = p / TABLE_SIZE;
			r = p % TABLE_SIZE;
			c = (quad == 0 || quad == 2) ? cos_q30((r <<< 30) / TABLE_SIZE)
				: cos_q30(64'sd1073741824 - (r <<< 30) / TABLE_SIZE);
			mag = (c * 32768 + 64'sd536870912) >>> 30;
			sine_tab[i] = (quad == 1 || quad == 2) ? 32768 - mag : 32768 + mag;
		end
		sh_wave = WF_SINE; sh_inc = 0; sh_loop = 1; sh_legato = 1; sh_steps_cfg = 16;
		sh_fade_en = 1; sh_fade_base = 0; sh_fade_coef = UNIT;
		lfo_phase = 0; lfo_wrapped_once = 0; lfo_step = 0; lfo_held = UNIT;
		lfo_end_latched = 0; lfo_end = 0; lfo_fade = 0; lfo_keys = 0;
		lfo_noise = 16'hACE1;
	endfunction

	function automatic void shadow_cfg(cfg_reg_t r, longint d);
		case (r)
			CR_WAVEFORM:   sh_wave = d[2:0];
			CR_PHASE_INC:  sh_inc = d & 64'h7FFFFFF;
			CR_LOOP:       sh_loop = d[0];
			CR_LEGATO:     sh_legato = d[0];
			CR_STEP_COUNT: sh_steps_cfg = int'(d & 64'hFF);
			CR_FADE_EN:    sh_fade_en = d[0];
			CR_FADE_BASE:  sh_fade_base = d & 64'h1FFFF;
			default:       sh_fade_coef = d & 64'h1FFFF;
		endcase
	endfunction

	// one control tick: returns the modulation value and advances the state
	function automatic logic [VW-1:0] lfo_tick();
		longint sum, cycles, w, fresh, a, b, frac, mix, f;
		int n, idx;
		bit wrap;
		sum = lfo_phase + sh_inc;
		cycles = sum / PHASE_WRAP;
		wrap = cycles != 0;
		if (sh_wave == WF_RANDOM) begin
			if (wrap) begin
				lfo_noise = lfo_noise[0] ? (lfo_noise >> 1) ^ 16'hB400 : lfo_noise >> 1;
				lfo_held = lfo_noise;
			end
			w = lfo_held;
		end else if (sh_wave == WF_STEPS) begin
			n = (sh_steps_cfg == 0) ? 1 : (sh_steps_cfg > MAX_STEPS) ? MAX_STEPS : sh_steps_cfg;
			if (!wrap) w = lfo_held;
			else if (!sh_loop && lfo_step + 1 == n) begin
				// last step reached without looping: hold the end value
				if (!lfo_end_latched) begin
					lfo_end = UNIT - lfo_step_vals[n - 1];
					lfo_end_latched = 1;
				end
				lfo_held = lfo_end;
				w = lfo_end;
			end else begin
				lfo_step = int'((lfo_step + cycles % n) % n);
				fresh = UNIT - lfo_step_vals[lfo_step];
				w = (fresh + lfo_held) >> 1;
				lfo_held = fresh;
			end
		end else if (!sh_loop && sh_wave == WF_CUSTOM &&
			(lfo_wrapped_once || lfo_phase > (longint'(TABLE_SIZE - 1) << PHASE_FRACTION_BITS))) begin
			if (!lfo_end_latched) begin
				lfo_end = UNIT - lfo_custom[TABLE_SIZE - 1];
				lfo_end_latched = 1;
			end
			w = lfo_end;
		end else begin
			idx = int'(lfo_phase >> PHASE_FRACTION_BITS) % TABLE_SIZE;
			a = shape_value(sh_wave, idx);
			b = shape_value(sh_wave, (idx + 1) % TABLE_SIZE);
			frac = lfo_phase & ((64'sd1 << PHASE_FRACTION_BITS) - 1);
			mix = (a * ((64'sd1 << PHASE_FRACTION_BITS) - frac) + b * frac) >> PHASE_FRACTION_BITS;
			if (mix > UNIT) mix = UNIT;
			w = UNIT - mix;
		end
		if (sh_fade_en || lfo_fade < UNIT) begin
			f = sh_fade_base + ((lfo_fade * sh_fade_coef) >> 16);
			lfo_fade = (f > UNIT) ? UNIT : f;
		end else lfo_fade = UNIT;
		if (wrap) lfo_wrapped_once = 1;
		lfo_phase = sum % PHASE_WRAP;
		return VW'(UNIT - ((w * lfo_fade) >> 16));
	endfunction

	// applies an accepted request; returns 1 and the value when it yields a result
	function automatic bit lfo_request(logic [2:0] op, int addr, longint val,
		output logic [VW-1:0] value);
		value = '0;
		if (val > UNIT) val = UNIT;
		case (op)
			OP_TICK: begin
				value = lfo_tick();
				return 1;
			end
			OP_NOTE_ON: begin
				if (!sh_legato || lfo_keys == 0) begin
					lfo_phase = 0; lfo_wrapped_once = 0; lfo_end_latched = 0;
					if (sh_wave == WF_STEPS) begin
						lfo_step = 0;
						lfo_held = UNIT - lfo_step_vals[0];
					end
					lfo_fade = sh_fade_en ? 0 : UNIT;
				end
				if (lfo_keys < 255) lfo_keys++;
			end
			OP_NOTE_OFF:  if (lfo_keys > 0) lfo_keys--;
			OP_ALL_OFF:   lfo_keys = 0;
			OP_WR_CUSTOM: if (addr < TABLE_SIZE) lfo_custom[addr] = val;
			OP_WR_STEP:   if (addr < MAX_STEPS) lfo_step_vals[addr] = val;
			default: ;
		endcase
		return 0;
	endfunction

	// ---------------------------------------------------------------
	// Request driver and config writer
	// ---------------------------------------------------------------
	// typed: the expected value is given by the caller instead of the shadow
	task automatic send_request(logic [2:0] op, int addr, int val, bit typed, int want);
		logic [VW-1:0] v;
		if ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.operation <= op;
		req_ch.table_address <= ADDR_W'(addr);
		req_ch.table_value <= VW'(val);
		do @(posedge clk); while (!req_ch.ready);
		if (lfo_request(op, addr, val, v)) mod_expected.push_back(typed ? VW'(want) : v);
	endtask

	// block is idle only once every tick is answered and trailing requests are done
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (mod_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, int d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr <= r;
		cfg_ch.data <= CFG_DW'(d);
		do @(posedge clk); while (!cfg_ch.ready);
		shadow_cfg(r, d);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Result checker with random back-pressure
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (mod_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result mod_value=%0d", res_ch.mod_value);
			end else begin
				if (res_ch.mod_value !== mod_expected[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mod_value mismatch: expected %0d got %0d",
							mod_expected[0], res_ch.mod_value);
				end
				void'(mod_expected.pop_front());
			end
		end
		res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Directed table
	// ---------------------------------------------------------------
	typedef struct {
		bit         is_cfg;
		cfg_reg_t   creg;
		int         cdata;
		logic [2:0] op;
		int         addr;
		int         val;
		bit         typed;
		int         want;
	} row_t;

	row_t rows [$];

	function automatic row_t cfg_row(cfg_reg_t r, int d);
		row_t x;
		x = '{1, r, d, OP_TICK, 0, 0, 0, 0};
		return x;
	endfunction

	function automatic row_t req_row(logic [2:0] op, int addr, int val, bit typed, int want);
		row_t x;
		x = '{0, CR_WAVEFORM, 0, op, addr, val, typed, want};
		return x;
	endfunction

	// random config biased toward the extremes
	task automatic random_config();
		int pick;
		int wf;
		wait_idle();
		// the custom table is only partly written, so custom mode stays directed
		wf = $urandom_range(0, 7);
		if (wf == WF_CUSTOM) wf = WF_STEPS;
		write_reg(CR_WAVEFORM, wf);
		pick = $urandom_range(5);
		write_reg(CR_PHASE_INC, pick == 0 ? 0 : pick == 1 ? 134217727 :
			pick == 2 ? $urandom_range(0, 134217727) : pick == 3 ? $urandom_range(0, 70000) :
			$urandom_range(33554432, 134217727));
		write_reg(CR_LOOP, $urandom_range(1));
		write_reg(CR_LEGATO, $urandom_range(1));
		pick = $urandom_range(9);
		write_reg(CR_STEP_COUNT, pick == 0 ? 0 : pick == 1 ? 255 : pick == 2 ? 128 :
			pick < 5 ? $urandom_range(1, 128) : $urandom_range(1, 6));
		write_reg(CR_FADE_EN, $urandom_range(1));
		pick = $urandom_range(4);
		write_reg(CR_FADE_BASE, pick == 0 ? 0 : pick == 1 ? 65536 :
			pick == 2 ? $urandom_range(0, 4000) : $urandom_range(0, 65536));
		pick = $urandom_range(4);
		write_reg(CR_FADE_COEF, pick == 0 ? 0 : pick == 1 ? 65536 :
			pick == 2 ? $urandom_range(60000, 65536) : $urandom_range(0, 65536));
	endtask

	task automatic random_request();
		int pick;
		logic [2:0] op;
		pick = $urandom_range(99);
		if (pick < 68) op = OP_TICK;
		else if (pick < 77) op = OP_NOTE_ON;
		else if (pick < 83) op = OP_NOTE_OFF;
		else if (pick < 85) op = OP_ALL_OFF;
		else if (pick < 91) op = OP_WR_CUSTOM;
		else if (pick < 97) op = OP_WR_STEP;
		else op = pick[0] ? OP_BAD_LO : OP_BAD_HI;
		send_request(op, $urandom_range(0, 2047), $urandom_range(0, 131071), 0, 0);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0; cfg_ch.addr = '0; cfg_ch.data = '0;
		req_ch.valid = 1'b0; req_ch.operation = '0;
		req_ch.table_address = '0; req_ch.table_value = '0;
		res_ch.ready = 1'b0;
		mismatches = 0; cycle_count = 0;
		send_idle_pct = 0; recv_idle_pct = 0;
		lfo_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the step store and the custom entries the directed rows read
		for (int i = 0; i < 2; i++)
			send_request(OP_WR_CUSTOM, i, $urandom_range(0, 65536), 0, 0);
		for (int i = 0; i < MAX_STEPS; i++)
			send_request(OP_WR_STEP, i, $urandom_range(0, 65536), 0, 0);

		// reset config: fade level stays at zero, so output is full scale
		rows.push_back(req_row(OP_TICK, 0, 0, 1, 65536));
		rows.push_back(req_row(OP_TICK, 0, 0, 1, 65536));
		rows.push_back(req_row(OP_BAD_LO, 2047, 131071, 0, 0));
		rows.push_back(req_row(OP_BAD_HI, 0, 0, 0, 0));
		rows.push_back(req_row(OP_NOTE_OFF, 0, 0, 0, 0));       // key count floor
		rows.push_back(req_row(OP_ALL_OFF, 0, 0, 0, 0));
		rows.push_back(req_row(OP_WR_CUSTOM, 2047, 131071, 0, 0)); // saturates
		rows.push_back(req_row(OP_WR_STEP, 2047, 0, 0, 0));      // beyond store, ignored
		rows.push_back(req_row(OP_WR_STEP, 127, 0, 0, 0));
		rows.push_back(cfg_row(CR_FADE_EN, 0));
		rows.push_back(cfg_row(CR_PHASE_INC, 134217727));
		rows.push_back(req_row(OP_NOTE_ON, 0, 0, 0, 0));         // restart, fade level 1.0
		rows.push_back(req_row(OP_TICK, 0, 0, 1, 65536));        // sine peak at phase 0
		rows.push_back(req_row(OP_TICK, 0, 0, 0, 0));
		rows.push_back(cfg_row(CR_WAVEFORM, WF_INVALID));        // acts as sine
		rows.push_back(req_row(OP_TICK, 0, 0, 0, 0));
		// custom table without looping latches the last entry
		rows.push_back(cfg_row(CR_WAVEFORM, WF_CUSTOM));
		rows.push_back(cfg_row(CR_LOOP, 0));
		rows.push_back(req_row(OP_ALL_OFF, 0, 0, 0, 0));
		rows.push_back(req_row(OP_NOTE_ON, 0, 0, 0, 0));
		rows.push_back(req_row(OP_TICK, 0, 0, 0, 0));
		rows.push_back(req_row(OP_TICK, 0, 0, 0, 0));
		rows.push_back(req_row(OP_TICK, 0, 0, 1, 65536));        // end value 1.0 - 1.0 is zero
		// steps: count 0 behaves as one step, then above the maximum
		rows.push_back(cfg_row(CR_WAVEFORM, WF_STEPS));
		rows.push_back(cfg_row(CR_STEP_COUNT, 0));
		rows.push_back(req_row(OP_TICK, 0, 0, 0, 0));
		rows.push_back(req_row(OP_TICK, 0, 0, 0, 0));
		rows.push_back(cfg_row(CR_STEP_COUNT, 200));
		rows.push_back(cfg_row(CR_LEGATO, 0));
		rows.push_back(req_row(OP_NOTE_ON, 0, 0, 0, 0));
		rows.push_back(req_row(OP_TICK, 0, 0, 0, 0));
		rows.push_back(cfg_row(CR_WAVEFORM, WF_RANDOM));
		rows.push_back(req_row(OP_TICK, 0, 0, 0, 0));
		rows.push_back(req_row(OP_TICK, 0, 0, 0, 0));

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				wait_idle();
				write_reg(rows[i].creg, rows[i].cdata);
			end else send_request(rows[i].op, rows[i].addr, rows[i].val,
				rows[i].typed, rows[i].want);
		end

		// random part: three idle profiles, fresh config every 80 requests
		for (int prof = 0; prof < 3; prof++) begin
			send_idle_pct = (prof == 0) ? 35 : (prof == 1) ? 48 : 0;
			recv_idle_pct = (prof == 0) ? 48 : (prof == 1) ? 35 : 0;
			for (int n = 0; n < 600; n++) begin
				if (n % 80 == 0) random_config();
				random_request();
			end
		end

		wait_idle();
		if (mismatches == 0) $display("testbench: PASS");
		else $display("testbench: FAIL");
		$finish;
	end

endmodule
